// ===== rtl/u8c_pkg.sv =====
// UTF-8 sequence codec package: item types, field constants and the lead byte
// length class function. No dependencies; used by every other file of the block.
package u8c_pkg;

  localparam logic [20:0] CpMax1 = 21'h00007f;
  localparam logic [20:0] CpMax2 = 21'h0007ff;
  localparam logic [20:0] CpMax3 = 21'h00ffff;
  localparam logic [20:0] CpMax4 = 21'h10ffff;
  localparam logic [2:0]  AvailMax = 3'd4;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } u8c_op_t;

  typedef struct packed {
    u8c_op_t     op;
    logic [7:0]  in_byte0;
    logic [7:0]  in_byte1;
    logic [7:0]  in_byte2;
    logic [7:0]  in_byte3;
    logic [2:0]  bytes_available;
    logic [20:0] in_code_point;
  } u8c_in_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  seq_length;
    logic [20:0] out_code_point;
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [7:0]  out_byte3;
    logic [2:0]  lead_class;
  } u8c_res_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  len;
    logic [20:0] cp;
  } u8c_dec_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  len;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
  } u8c_enc_t;

  // 0 continuation, 4/3/2 multi-byte leads, 1 for ASCII and F8-FF
  function automatic logic [2:0] lead_class_of(input logic [7:0] b);
    logic [2:0] cls;
    if (b[7:6] == 2'b10) begin
      cls = 3'd0;
    end else if (b[7:3] == 5'b11110) begin
      cls = 3'd4;
    end else if (b[7:4] == 4'b1110) begin
      cls = 3'd3;
    end else if (b[7:5] == 3'b110) begin
      cls = 3'd2;
    end else begin
      cls = 3'd1;
    end
    return cls;
  endfunction

endpackage

// ===== rtl/u8c_if.sv =====
// Valid/ready channel interfaces for the UTF-8 codec request and result items.
// Depends on u8c_pkg for the payload types.
interface u8c_req_if import u8c_pkg::*; ();
  logic    valid;
  logic    ready;
  u8c_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface u8c_rsp_if import u8c_pkg::*; ();
  logic     valid;
  logic     ready;
  u8c_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/u8c_decode.sv =====
// UTF-8 decoder: lead byte, continuation checks and code point assembly.
// Pure combinational; depends on u8c_pkg.
module u8c_decode import u8c_pkg::*; (
  input  u8c_in_t  item,
  output u8c_dec_t res
);

  logic [2:0]  avail;
  logic [2:0]  need;
  logic        lead_ok;
  logic        cont_ok;
  logic [20:0] val;
  logic        c1, c2, c3;

  assign avail = (item.bytes_available > AvailMax) ? AvailMax : item.bytes_available;
  assign c1 = (item.in_byte1[7:6] == 2'b10);
  assign c2 = (item.in_byte2[7:6] == 2'b10);
  assign c3 = (item.in_byte3[7:6] == 2'b10);

  always_comb begin
    lead_ok = 1'b1;
    need    = 3'd1;
    cont_ok = 1'b1;
    val     = {13'd0, item.in_byte0};
    if (item.in_byte0[7] == 1'b0) begin
      need = 3'd1;
    end else if (item.in_byte0[7:5] == 3'b110) begin
      need    = 3'd2;
      cont_ok = c1;
      val     = {10'd0, item.in_byte0[4:0], item.in_byte1[5:0]};
    end else if (item.in_byte0[7:4] == 4'b1110) begin
      need    = 3'd3;
      cont_ok = c1 & c2;
      val     = {5'd0, item.in_byte0[3:0], item.in_byte1[5:0], item.in_byte2[5:0]};
    end else if (item.in_byte0[7:3] == 5'b11110) begin
      need    = 3'd4;
      cont_ok = c1 & c2 & c3;
      val     = {item.in_byte0[2:0], item.in_byte1[5:0], item.in_byte2[5:0],
                 item.in_byte3[5:0]};
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    res = '0;
    if (lead_ok && cont_ok && (need <= avail)) begin
      res.ok  = 1'b1;
      res.len = need;
      res.cp  = val;
    end
  end

endmodule

// ===== rtl/u8c_encode.sv =====
// UTF-8 encoder: splits a code point into one to four bytes by range.
// Pure combinational; depends on u8c_pkg.
module u8c_encode import u8c_pkg::*; (
  input  logic [20:0] cp,
  output u8c_enc_t    res
);

  always_comb begin
    res = '0;
    if (cp <= CpMax1) begin
      res.ok  = 1'b1;
      res.len = 3'd1;
      res.b0  = cp[7:0];
    end else if (cp <= CpMax2) begin
      res.ok  = 1'b1;
      res.len = 3'd2;
      res.b0  = {3'b110, cp[10:6]};
      res.b1  = {2'b10, cp[5:0]};
    end else if (cp <= CpMax3) begin
      res.ok  = 1'b1;
      res.len = 3'd3;
      res.b0  = {4'b1110, cp[15:12]};
      res.b1  = {2'b10, cp[11:6]};
      res.b2  = {2'b10, cp[5:0]};
    end else if (cp <= CpMax4) begin
      res.ok  = 1'b1;
      res.len = 3'd4;
      res.b0  = {5'b11110, cp[20:18]};
      res.b1  = {2'b10, cp[17:12]};
      res.b2  = {2'b10, cp[11:6]};
      res.b3  = {2'b10, cp[5:0]};
    end
  end

endmodule

// ===== rtl/utf8_sequence_codec.sv =====
// UTF-8 sequence codec top level: input register, decoder, encoder, result register.
// Depends on u8c_pkg, u8c_if, u8c_decode and u8c_encode.
//
// Usage: items arrive on req (valid/ready); op selects decode of in_byte0..3
// (with bytes_available bytes present) or encode of in_code_point. One result
// item per request leaves on rsp: ok, seq_length, out_code_point, out_byte0..3
// and the length class of in_byte0, which is reported for either op.
// Path: an accepted item sits in the input register with the decode/encode logic
// behind it, moves into the result register once that register is empty or being
// taken, then waits there until rsp takes it.
// Throughput: one item per cycle, sustained while rsp is taken.
// Stalls: when rsp is not taken the result register holds; the input register
// still takes one more item, then req.ready drops until rsp moves again.
// Reset (rst, synchronous): both stages empty, nothing in flight is kept.
module utf8_sequence_codec import u8c_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  u8c_req_if.sink   req,
  u8c_rsp_if.source rsp
);

  logic     s1_valid;
  u8c_in_t  s1_data;
  logic     out_valid;
  u8c_res_t out_data;
  logic     s1_advance;
  u8c_dec_t dec_res;
  u8c_enc_t enc_res;
  u8c_res_t res_next;

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;

  u8c_decode u_decode (
    .item (s1_data),
    .res  (dec_res)
  );

  u8c_encode u_encode (
    .cp  (s1_data.in_code_point),
    .res (enc_res)
  );

  always_comb begin
    res_next            = '0;
    res_next.lead_class = lead_class_of(s1_data.in_byte0);
    if (s1_data.op == OP_DECODE) begin
      res_next.ok             = dec_res.ok;
      res_next.seq_length     = dec_res.len;
      res_next.out_code_point = dec_res.cp;
    end else begin
      res_next.ok         = enc_res.ok;
      res_next.seq_length = enc_res.len;
      res_next.out_byte0  = enc_res.b0;
      res_next.out_byte1  = enc_res.b1;
      res_next.out_byte2  = enc_res.b2;
      res_next.out_byte3  = enc_res.b3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_data <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= res_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

`ifndef SYNTHESIS
  // a failed item carries no length, no code point and no first output byte
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.ok |-> rsp.data.seq_length == 3'd0 &&
      rsp.data.out_code_point == 21'd0 && rsp.data.out_byte0 == 8'd0)
    else $error("u8c: failed result carries data");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.ok |-> rsp.data.seq_length != 3'd0 &&
      rsp.data.seq_length <= 3'd4)
    else $error("u8c: good result with bad length");

  // a decode result never carries encoded bytes
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.out_code_point != 21'd0 |-> rsp.data.out_byte0 == 8'd0 &&
      rsp.data.out_byte1 == 8'd0)
    else $error("u8c: decode result with encoded bytes");

  // a held input item moves into an empty result register
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("u8c: pipeline bubble with item waiting");
`endif

endmodule

// ===== bench/tb_utf8_sequence_codec.sv =====
`timescale 1ns / 100ps
// Testbench for utf8_sequence_codec: directed decode/encode cases, then random traffic.
// Depends on u8c_pkg, u8c_if and the codec RTL; results are checked against a local predictor.
module tb_utf8_sequence_codec import u8c_pkg::*; ();

  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst;

  u8c_req_if req_ch ();
  u8c_rsp_if rsp_ch ();

  utf8_sequence_codec u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  u8c_res_t predicted_results[$];
  int       fail_count = 0;
  int       checked_count = 0;
  int       decode_count = 0;
  int       encode_count = 0;
  int       cycle_count = 0;
  int       stall_pct = 0;
  int       stall_left = 0;

  // Bit-exact expectation for one request item
  function automatic u8c_res_t codec_result_for(input u8c_in_t it);
    u8c_res_t    res;
    logic [7:0]  seq[4];
    logic [20:0] val;
    logic [20:0] cp;
    int          need;
    int          avail;
    logic        good;
    res = '0;
    seq[0] = it.in_byte0;
    seq[1] = it.in_byte1;
    seq[2] = it.in_byte2;
    seq[3] = it.in_byte3;
    cp = it.in_code_point;

    casez (seq[0])
      8'b10??????: res.lead_class = 3'd0;
      8'b11110???: res.lead_class = 3'd4;
      8'b1110????: res.lead_class = 3'd3;
      8'b110?????: res.lead_class = 3'd2;
      default:     res.lead_class = 3'd1;
    endcase

    if (it.op == OP_DECODE) begin
      avail = (it.bytes_available > 3'd4) ? 4 : int'(it.bytes_available);
      good = 1'b1;
      need = 0;
      val = '0;
      casez (seq[0])
        8'b0???????: begin
          need = 1;
          val = {14'd0, seq[0][6:0]};
        end
        8'b110?????: begin
          need = 2;
          val = {16'd0, seq[0][4:0]};
        end
        8'b1110????: begin
          need = 3;
          val = {17'd0, seq[0][3:0]};
        end
        8'b11110???: begin
          need = 4;
          val = {18'd0, seq[0][2:0]};
        end
        default: good = 1'b0;
      endcase
      if (good && need > avail) good = 1'b0;
      for (int i = 1; i < need; i++) begin
        if (seq[i][7:6] != 2'b10) good = 1'b0;
        val = {val[14:0], seq[i][5:0]};
      end
      if (good) begin
        res.ok = 1'b1;
        res.seq_length = 3'(need);
        res.out_code_point = val;
      end
    end else begin
      if (cp <= CpMax1) begin
        res.out_byte0 = cp[7:0];
        res.seq_length = 3'd1;
        res.ok = 1'b1;
      end else if (cp <= CpMax2) begin
        res.out_byte0 = {3'b110, cp[10:6]};
        res.out_byte1 = {2'b10, cp[5:0]};
        res.seq_length = 3'd2;
        res.ok = 1'b1;
      end else if (cp <= CpMax3) begin
        res.out_byte0 = {4'b1110, cp[15:12]};
        res.out_byte1 = {2'b10, cp[11:6]};
        res.out_byte2 = {2'b10, cp[5:0]};
        res.seq_length = 3'd3;
        res.ok = 1'b1;
      end else if (cp <= CpMax4) begin
        res.out_byte0 = {5'b11110, cp[20:18]};
        res.out_byte1 = {2'b10, cp[17:12]};
        res.out_byte2 = {2'b10, cp[11:6]};
        res.out_byte3 = {2'b10, cp[5:0]};
        res.seq_length = 3'd4;
        res.ok = 1'b1;
      end
    end
    return res;
  endfunction

  // Decode item; the code point is noise and must be ignored
  function automatic u8c_in_t decode_item(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [2:0] avail);
    u8c_in_t it;
    it.op = OP_DECODE;
    it.in_byte0 = b0;
    it.in_byte1 = b1;
    it.in_byte2 = b2;
    it.in_byte3 = b3;
    it.bytes_available = avail;
    it.in_code_point = 21'($urandom);
    return it;
  endfunction

  // Encode item; the decode bytes are noise and must be ignored
  function automatic u8c_in_t encode_item(input logic [20:0] cp);
    u8c_in_t it;
    it.op = OP_ENCODE;
    it.in_byte0 = 8'($urandom);
    it.in_byte1 = 8'($urandom);
    it.in_byte2 = 8'($urandom);
    it.in_byte3 = 8'($urandom);
    it.bytes_available = 3'($urandom_range(0, 7));
    it.in_code_point = cp;
    return it;
  endfunction

  // Mostly well-formed sequences and in-range code points, the rest noise or broken
  function automatic u8c_in_t random_item();
    u8c_in_t    it;
    logic [7:0] seq[4];
    int         kind;
    int         need;
    int         k;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      case ($urandom_range(0, 4))
        0:       it = encode_item(21'($urandom_range(0, 'h7f)));
        1:       it = encode_item(21'($urandom_range('h80, 'h7ff)));
        2:       it = encode_item(21'($urandom_range('h800, 'hffff)));
        3:       it = encode_item(21'($urandom_range('h10000, 'h10ffff)));
        default: it = encode_item(21'($urandom_range('h110000, 'h1fffff)));
      endcase
      return it;
    end
    for (int i = 0; i < 4; i++) seq[i] = 8'($urandom);
    it = decode_item(seq[0], seq[1], seq[2], seq[3], 3'($urandom_range(0, 7)));
    if (kind < 50) return it;

    need = $urandom_range(1, 4);
    case (need)
      1:       seq[0] = 8'($urandom_range(0, 'h7f));
      2:       seq[0] = 8'hc0 | 8'($urandom_range(0, 31));
      3:       seq[0] = 8'he0 | 8'($urandom_range(0, 15));
      default: seq[0] = 8'hf0 | 8'($urandom_range(0, 7));
    endcase
    for (int i = 1; i < need; i++) seq[i] = 8'h80 | 8'($urandom_range(0, 63));
    if ($urandom_range(0, 9) != 0) it.bytes_available = 3'($urandom_range(need, 7));

    if (kind >= 85) begin
      if (need > 1 && $urandom_range(0, 1) == 1) begin
        // continuation byte without the 10 prefix
        k = $urandom_range(1, need - 1);
        case ($urandom_range(0, 2))
          0:       seq[k][7:6] = 2'b00;
          1:       seq[k][7:6] = 2'b01;
          default: seq[k][7:6] = 2'b11;
        endcase
      end else begin
        it.bytes_available = 3'($urandom_range(0, need - 1));
      end
    end
    it.in_byte0 = seq[0];
    it.in_byte1 = seq[1];
    it.in_byte2 = seq[2];
    it.in_byte3 = seq[3];
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input u8c_in_t it);
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted_results.push_back(codec_result_for(it));
    if (it.op == OP_DECODE) decode_count++;
    else encode_count++;
    @(negedge clk);
  endtask

  task automatic test_decode_cases();
    stall_pct = 20;
    send_item(decode_item(8'h00, 8'hff, 8'hff, 8'hff, 3'd1));
    send_item(decode_item(8'h7f, 8'h80, 8'h80, 8'h80, 3'd1));
    send_item(decode_item(8'hc2, 8'ha9, 8'h00, 8'h00, 3'd2));
    send_item(decode_item(8'he2, 8'h82, 8'hac, 8'hff, 3'd3));
    send_item(decode_item(8'hef, 8'hbf, 8'hbf, 8'h00, 3'd3));
    send_item(decode_item(8'hf0, 8'h9f, 8'h98, 8'h80, 3'd4));
    // saturating byte count, top of the Unicode range
    send_item(decode_item(8'hf4, 8'h8f, 8'hbf, 8'hbf, 3'd7));
    // leads F5-F7 are let through
    send_item(decode_item(8'hf7, 8'hbf, 8'hbf, 8'hbf, 3'd4));
    send_item(decode_item(8'h80, 8'h80, 8'h80, 8'h80, 3'd4));
    send_item(decode_item(8'hf8, 8'h80, 8'h80, 8'h80, 3'd4));
    send_item(decode_item(8'hff, 8'hbf, 8'hbf, 8'hbf, 3'd4));
    send_item(decode_item(8'he2, 8'h82, 8'hac, 8'h00, 3'd2));
    send_item(decode_item(8'hc2, 8'h41, 8'h00, 8'h00, 3'd4));
    // nothing available fails even for ASCII
    send_item(decode_item(8'h41, 8'h00, 8'h00, 8'h00, 3'd0));
    // overlong and surrogate forms pass unchecked
    send_item(decode_item(8'hc0, 8'h80, 8'h00, 8'h00, 3'd2));
    send_item(decode_item(8'hed, 8'ha0, 8'h80, 8'h00, 3'd5));
    req_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_encode_cases();
    logic [20:0] points[10];
    points = '{21'h0, 21'h7f, 21'h80, 21'h7ff, 21'h800, 21'hffff, 21'h10000,
               21'h10ffff, 21'h110000, 21'h1fffff};
    stall_pct = 40;
    foreach (points[i]) send_item(encode_item(points[i]));
    req_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Bursts of items with random gaps between them
  task automatic test_mixed_traffic(input int count, input int gap_pct, input int stall);
    int burst;
    int sent;
    sent = 0;
    stall_pct = stall;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_item(random_item());
        sent++;
      end
      if ($urandom_range(0, 99) < gap_pct) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    req_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver back-pressure: stalls of random length at a set rate
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 5);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    u8c_res_t want;
    u8c_res_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %p", $time, got);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        compare_field("ok", 32'(want.ok), 32'(got.ok));
        compare_field("seq_length", 32'(want.seq_length), 32'(got.seq_length));
        compare_field("out_code_point", 32'(want.out_code_point),
                      32'(got.out_code_point));
        compare_field("out_byte0", 32'(want.out_byte0), 32'(got.out_byte0));
        compare_field("out_byte1", 32'(want.out_byte1), 32'(got.out_byte1));
        compare_field("out_byte2", 32'(want.out_byte2), 32'(got.out_byte2));
        compare_field("out_byte3", 32'(want.out_byte3), 32'(got.out_byte3));
        compare_field("lead_class", 32'(want.lead_class), 32'(got.lead_class));
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, predicted_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_decode_cases();
    test_encode_cases();
    test_mixed_traffic(500, 0, 0);
    test_mixed_traffic(500, 30, 20);
    test_mixed_traffic(550, 60, 50);

    stall_pct = 0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d decode and %0d encode items under varied gaps and stalls,",
             decode_count, encode_count);
    $display("%0d results compared, %0d mismatches.", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== utf8_sequence_codec.f =====
rtl/u8c_pkg.sv
rtl/u8c_if.sv
rtl/u8c_decode.sv
rtl/u8c_encode.sv
rtl/utf8_sequence_codec.sv
bench/tb_utf8_sequence_codec.sv
